// ===== hw/rtl/dcph_pkg.sv =====
// Shared types, constants and helper functions for the daisy-chain position handshake.
// Used by the front, queue, back, top level and checker; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dcph_pkg;

  // Serial vector length and the number of results one address send produces
  localparam int VECTOR_BITS  = 8;
  localparam int SEND_RESULTS = 4 + 2 * VECTOR_BITS + 1;
  localparam int IDX_W        = $clog2(SEND_RESULTS);

  // Bit positions inside the pin drive level word
  localparam logic [3:0] D_LEFT  = 4'd0;
  localparam logic [3:0] D_BELOW = 4'd2;
  localparam logic [3:0] D_DATA  = 4'd4;
  localparam logic [3:0] D_CLK   = 4'd5;
  localparam logic [3:0] D_ABOVE = 4'd6;
  localparam logic [3:0] D_RIGHT = 4'd8;

  localparam logic [11:0] PDL_RESET = 12'h005;

  // Address field masks
  localparam logic [7:0] X_MASK = 8'b0000_0111;
  localparam logic [7:0] Y_MASK = 8'b0111_1000;

  // Slave select drive codes
  localparam logic [1:0] SDRV_RELEASED = 2'd0;
  localparam logic [1:0] SDRV_LOW      = 2'd1;
  localparam logic [1:0] SDRV_HIGH     = 2'd2;
  localparam logic [1:0] SDRV_PULLUP   = 2'd3;

  // Master select drive codes
  localparam logic [1:0] MDRV_RELEASED = 2'd0;
  localparam logic [1:0] MDRV_LOW      = 2'd1;
  localparam logic [1:0] MDRV_HIGH     = 2'd2;

  // Input command codes
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  typedef enum logic [3:0] {
    PH_POWER_ON     = 4'd0,
    PH_START_SLAVE  = 4'd1,
    PH_SLAVE_A      = 4'd2,
    PH_SLAVE_B      = 4'd3,
    PH_SERIAL_SLAVE = 4'd4,
    PH_START_MASTER = 4'd5,
    PH_MASTER_A     = 4'd6,
    PH_MASTER_B     = 4'd7,
    PH_MASTER_SEND  = 4'd8
  } phase_t;

  typedef enum logic [1:0] {
    JOB_ONE  = 2'd0,
    JOB_TWO  = 2'd1,
    JOB_SEND = 2'd2
  } job_kind_t;

  typedef struct packed {
    logic       cmd;
    logic       slave_clock;
    logic       slave_data;
    logic       from_left_select;
    logic       from_below_select;
    logic       to_above_select;
    logic       to_right_select;
  } in_item_t;

  typedef struct packed {
    logic [3:0] phase;
    logic [1:0] left_select_drive;
    logic [1:0] below_select_drive;
    logic       master_data_out;
    logic       master_clock_out;
    logic [1:0] above_select_drive;
    logic [1:0] right_select_drive;
    logic [6:0] position_address;
    logic       address_valid;
  } out_rec_t;

  // One queued request for the back part: up to two ready records or an address send
  typedef struct packed {
    job_kind_t kind;
    logic      serve_above;
    out_rec_t  rec_a;
    out_rec_t  rec_b;
  } job_t;

  function automatic logic [1:0] slave_code(input logic dir, input logic lvl);
    logic [1:0] code;
    if (dir) code = lvl ? SDRV_HIGH : SDRV_LOW;
    else     code = lvl ? SDRV_PULLUP : SDRV_RELEASED;
    return code;
  endfunction

  function automatic logic [1:0] master_code(input logic dir, input logic lvl);
    logic [1:0] code;
    if (!dir) code = MDRV_RELEASED;
    else      code = lvl ? MDRV_HIGH : MDRV_LOW;
    return code;
  endfunction

  // Build a result record from the protocol phase, pin drives and address
  function automatic out_rec_t make_rec(input logic [3:0] ph, input logic [11:0] pdl,
                                        input logic [6:0] addr);
    out_rec_t r;
    r.phase              = ph;
    r.left_select_drive  = slave_code(pdl[D_LEFT], pdl[D_LEFT + 4'd1]);
    r.below_select_drive = slave_code(pdl[D_BELOW], pdl[D_BELOW + 4'd1]);
    r.master_data_out    = pdl[D_DATA];
    r.master_clock_out   = pdl[D_CLK];
    r.above_select_drive = master_code(pdl[D_ABOVE], pdl[D_ABOVE + 4'd1]);
    r.right_select_drive = master_code(pdl[D_RIGHT], pdl[D_RIGHT + 4'd1]);
    r.position_address   = addr;
    r.address_valid      = (ph >= PH_START_MASTER) && (ph <= PH_MASTER_SEND);
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/daisy_chain_position_handshake_core.sv =====
// Daisy-chain position handshake: an input request carries either a pin sample
// or a select toggle tick and yields zero, one, two or twenty-one results. The
// front part runs the protocol and can take one request per cycle while the
// two-entry job queue has room; the back part emits one result per cycle from
// its output register while results are popped. A request with one result thus
// sustains one per cycle, its result passing the job queue and then the output
// register; the address send occupies the result stage for all of its results,
// during which the queue holds one further request with results (ticks that
// yield nothing are still taken until the queue fills). No clearing pass follows
// reset. Top level: ties dcph_front, dcph_queue and dcph_back. Depends on dcph_pkg.
`timescale 1ns / 1ps
`default_nettype none

module daisy_chain_position_handshake_core (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_push,
  output logic            in_full,
  input  wire logic       in_cmd,
  input  wire logic       in_slave_clock,
  input  wire logic       in_slave_data,
  input  wire logic       in_from_left_select,
  input  wire logic       in_from_below_select,
  input  wire logic       in_to_above_select,
  input  wire logic       in_to_right_select,
  output logic            out_empty,
  input  wire logic       out_pop,
  output logic [3:0]      out_phase,
  output logic [1:0]      out_left_select_drive,
  output logic [1:0]      out_below_select_drive,
  output logic            out_master_data_out,
  output logic            out_master_clock_out,
  output logic [1:0]      out_above_select_drive,
  output logic [1:0]      out_right_select_drive,
  output logic [6:0]      out_position_address,
  output logic            out_address_valid,
  output logic            out_last
);
  import dcph_pkg::*;

  in_item_t item;
  job_t     push_job;
  job_t     head_job;
  out_rec_t rec;
  logic     item_ready;
  logic     q_push;
  logic     q_full;
  logic     q_not_empty;
  logic     job_pop;
  logic     res_valid;

  assign item = '{cmd: in_cmd, slave_clock: in_slave_clock, slave_data: in_slave_data,
                  from_left_select: in_from_left_select,
                  from_below_select: in_from_below_select,
                  to_above_select: in_to_above_select,
                  to_right_select: in_to_right_select};

  assign in_full = !item_ready;

  dcph_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (in_push),
    .item       (item),
    .q_full     (q_full),
    .item_ready (item_ready),
    .q_push     (q_push),
    .q_job      (push_job)
  );

  dcph_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_job  (push_job),
    .pop       (job_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head_job  (head_job)
  );

  dcph_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (q_not_empty),
    .job       (head_job),
    .res_pop   (out_pop),
    .job_pop   (job_pop),
    .res_valid (res_valid),
    .res_rec   (rec),
    .res_last  (out_last)
  );

  // Result ports
  assign out_empty              = !res_valid;
  assign out_phase              = rec.phase;
  assign out_left_select_drive  = rec.left_select_drive;
  assign out_below_select_drive = rec.below_select_drive;
  assign out_master_data_out    = rec.master_data_out;
  assign out_master_clock_out   = rec.master_clock_out;
  assign out_above_select_drive = rec.above_select_drive;
  assign out_right_select_drive = rec.right_select_drive;
  assign out_position_address   = rec.position_address;
  assign out_address_valid      = rec.address_valid;

endmodule

`default_nettype wire

// ===== hw/rtl/dcph_front.sv =====
// Front part: accepts input requests, runs the protocol state machine and
// queues a job describing the results. Depends on dcph_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dcph_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             item_valid,
  input  wire dcph_pkg::in_item_t item,
  input  wire logic             q_full,
  output logic                  item_ready,
  output logic                  q_push,
  output dcph_pkg::job_t        q_job
);
  import dcph_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [5:0]  prev_r, prev_nxt;
  logic        slc_r, slc_nxt;
  logic        efl_r, efl_nxt;
  logic        efb_r, efb_nxt;
  logic        sa_r, sa_nxt;
  logic [3:0]  br_r, br_nxt;
  logic [7:0]  rb_r, rb_nxt;
  logic [6:0]  addr_r, addr_nxt;
  logic [11:0] pdl_r, pdl_nxt;
  logic        accept;

  assign item_ready = !q_full;
  assign accept     = item_valid && !q_full;

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_START_SLAVE;
      prev_r  <= '0;
      slc_r   <= 1'b1;
      efl_r   <= 1'b0;
      efb_r   <= 1'b0;
      sa_r    <= 1'b0;
      br_r    <= 4'(VECTOR_BITS);
      rb_r    <= '0;
      addr_r  <= '0;
      pdl_r   <= PDL_RESET;
    end else if (accept) begin
      phase_r <= phase_nxt;
      prev_r  <= prev_nxt;
      slc_r   <= slc_nxt;
      efl_r   <= efl_nxt;
      efb_r   <= efb_nxt;
      sa_r    <= sa_nxt;
      br_r    <= br_nxt;
      rb_r    <= rb_nxt;
      addr_r  <= addr_nxt;
      pdl_r   <= pdl_nxt;
    end
  end

  // Next state and job
  always_comb begin
    logic [5:0] cur;
    logic [5:0] chg;
    logic       clk_rise;
    logic       clk_fall;
    logic       data;
    logic       sel_pin;
    logic [3:0] cp;
    logic [3:0] sp;
    logic       bch;
    logic       lch;
    logic       done;
    logic       has_res;
    logic [7:0] sum_x;
    logic [7:0] sum_y;
    logic [3:0] br_dec;

    phase_nxt = phase_r;
    prev_nxt  = prev_r;
    slc_nxt   = slc_r;
    efl_nxt   = efl_r;
    efb_nxt   = efb_r;
    sa_nxt    = sa_r;
    br_nxt    = br_r;
    rb_nxt    = rb_r;
    addr_nxt  = addr_r;
    pdl_nxt   = pdl_r;
    has_res   = 1'b1;
    q_job.kind        = JOB_ONE;
    q_job.serve_above = sa_r;
    q_job.rec_a       = '0;
    q_job.rec_b       = '0;

    cur = {item.to_right_select, item.to_above_select, item.from_below_select,
           item.from_left_select, item.slave_data, item.slave_clock};
    chg      = cur ^ prev_r;
    data     = cur[1];
    clk_rise = chg[0] && !prev_r[0];
    clk_fall = chg[0] && prev_r[0];
    sel_pin  = slc_r ? cur[2] : cur[3];
    cp       = slc_r ? D_LEFT : D_BELOW;
    sp       = sa_r ? D_ABOVE : D_RIGHT;
    bch      = chg[3] && !efl_r;
    lch      = chg[2] && !efb_r;
    done     = 1'b0;
    br_dec   = br_r - 4'd1;
    sum_x    = rb_r + {7'd0, efl_r};
    sum_y    = rb_r + {4'd0, efb_r, 3'd0};

    if (item.cmd == CMD_TICK) begin
      // Select toggle: only meaningful while waiting for a master
      if (phase_r == PH_START_SLAVE) begin
        if (pdl_r[cp + 4'd1]) begin
          pdl_nxt[cp + 4'd1] = 1'b0;
          q_job.rec_a = make_rec(phase_r, pdl_nxt, addr_r);
          q_job.kind  = JOB_TWO;
          slc_nxt     = !slc_r;
          pdl_nxt[(slc_r ? D_BELOW : D_LEFT) + 4'd1] = 1'b1;
        end else begin
          pdl_nxt[cp + 4'd1] = 1'b1;
        end
      end else begin
        has_res = 1'b0;
      end
    end else begin
      prev_nxt = cur;
      unique case (phase_r)
        PH_START_SLAVE: begin
          if (clk_rise && data) begin
            phase_nxt          = PH_SLAVE_A;
            pdl_nxt[cp + 4'd1] = 1'b0;
          end
        end
        PH_SLAVE_A: begin
          if (clk_fall) begin
            phase_nxt          = PH_SLAVE_B;
            pdl_nxt[cp + 4'd1] = 1'b1;
            q_job.rec_a        = make_rec(PH_SLAVE_B, pdl_nxt, addr_r);
            q_job.kind         = JOB_TWO;
            pdl_nxt[cp]        = 1'b0;
          end else begin
            phase_nxt = PH_START_SLAVE;
          end
        end
        PH_SLAVE_B: begin
          if (clk_rise && !data && !sel_pin) begin
            phase_nxt        = PH_SERIAL_SLAVE;
            pdl_nxt[D_LEFT]  = 1'b0;
            pdl_nxt[D_BELOW] = 1'b0;
          end else begin
            phase_nxt = PH_START_SLAVE;
          end
        end
        PH_SERIAL_SLAVE: begin
          if (bch) begin
            if (prev_r[3]) done = 1'b1;
            else           efb_nxt = 1'b1;
          end else if (lch) begin
            if (prev_r[2]) done = 1'b1;
            else           efl_nxt = 1'b1;
          end else if (clk_rise && br_r != 4'd0 && br_r <= 4'(VECTOR_BITS)) begin
            br_nxt = br_dec;
            rb_nxt = rb_r | (8'(data) << br_dec[2:0]);
          end
          if (done) begin
            br_nxt           = 4'(VECTOR_BITS);
            addr_nxt         = 7'((sum_x & X_MASK) | (sum_y & Y_MASK));
            phase_nxt        = PH_START_MASTER;
            pdl_nxt[D_ABOVE] = 1'b0;
            pdl_nxt[D_RIGHT] = 1'b0;
          end
        end
        PH_START_MASTER: begin
          if (chg[4] && !prev_r[4]) begin
            sa_nxt    = 1'b1;
            phase_nxt = PH_MASTER_A;
          end else if (chg[5] && !prev_r[5]) begin
            phase_nxt = PH_MASTER_A;
          end
          if (phase_nxt == PH_MASTER_A) begin
            pdl_nxt[D_DATA] = 1'b1;
            pdl_nxt[D_CLK]  = 1'b1;
          end
        end
        PH_MASTER_A: begin
          if ((chg[5:4] != 2'b00) && (prev_r[5:4] != 2'b00)) begin
            phase_nxt       = PH_MASTER_B;
            pdl_nxt[D_DATA] = 1'b0;
            pdl_nxt[D_CLK]  = 1'b0;
          end
        end
        PH_MASTER_B: begin
          if ((chg[5:4] != 2'b00) && (prev_r[5:4] == 2'b00)) begin
            phase_nxt          = PH_MASTER_SEND;
            q_job.kind         = JOB_SEND;
            q_job.rec_a        = make_rec(PH_MASTER_SEND, pdl_r, addr_r);
            // Pin state once the whole vector has gone out
            pdl_nxt[sp]        = 1'b1;
            pdl_nxt[sp + 4'd1] = 1'b0;
            pdl_nxt[D_DATA]    = addr_r[0];
            pdl_nxt[D_CLK]     = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end

    // Final record of the request
    if (q_job.kind == JOB_ONE) q_job.rec_a = make_rec(phase_nxt, pdl_nxt, addr_nxt);
    if (q_job.kind == JOB_TWO) q_job.rec_b = make_rec(phase_nxt, pdl_nxt, addr_nxt);
    q_push = accept && has_res;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/dcph_queue.sv =====
// Two-entry job queue between the front and back parts.
// Depends on dcph_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dcph_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire dcph_pkg::job_t push_job,
  input  wire logic           pop,
  output logic                full,
  output logic                not_empty,
  output dcph_pkg::job_t      head_job
);
  import dcph_pkg::*;

  job_t       slot_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic       do_push;
  logic       do_pop;

  assign full      = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign head_job  = slot_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= !wr_ptr_r;
      if (do_pop)  rd_ptr_r <= !rd_ptr_r;
      if (do_push && !do_pop)      count_r <= count_r + 2'd1;
      else if (!do_push && do_pop) count_r <= count_r - 2'd1;
    end
  end

  // Job storage
  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= push_job;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/dcph_back.sv =====
// Back part: expands queued jobs into result records, one per cycle while results
// are taken, into the output register. Depends on dcph_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dcph_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           job_valid,
  input  wire dcph_pkg::job_t job,
  input  wire logic           res_pop,
  output logic                job_pop,
  output logic                res_valid,
  output dcph_pkg::out_rec_t  res_rec,
  output logic                res_last
);
  import dcph_pkg::*;

  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             valid_r, valid_nxt;
  out_rec_t         rec_r, rec_nxt;
  logic             last_r, last_nxt;
  logic             load;

  assign res_valid = valid_r;
  assign res_rec   = rec_r;
  assign res_last  = last_r;
  assign load      = job_valid && (!valid_r || res_pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rec_r  <= rec_nxt;
      last_r <= last_nxt;
    end
  end

  // Record selection and address send sequencing
  always_comb begin
    logic [1:0]       sp_code;
    logic [IDX_W-1:0] tmp;
    logic [2:0]       bit_idx;
    logic [7:0]       addr8;
    logic [IDX_W-1:0] final_idx;

    rec_nxt   = job.rec_a;
    sp_code   = MDRV_LOW;
    tmp       = idx_r - IDX_W'(4);
    bit_idx   = ~tmp[3:1];
    addr8     = {1'b0, job.rec_a.position_address};
    final_idx = '0;

    case (job.kind)
      JOB_ONE: final_idx = '0;
      JOB_TWO: begin
        final_idx = IDX_W'(1);
        if (idx_r != '0) rec_nxt = job.rec_b;
      end
      JOB_SEND: begin
        final_idx = IDX_W'(SEND_RESULTS - 1);
        // Select line goes high after the start clock pulse, low at the end
        if (idx_r >= IDX_W'(3) && idx_r < final_idx) sp_code = MDRV_HIGH;
        rec_nxt.master_clock_out =
          (idx_r == IDX_W'(1)) || (idx_r >= IDX_W'(4) && idx_r < final_idx && !idx_r[0]);
        if (idx_r == final_idx)     rec_nxt.master_data_out = addr8[0];
        else if (idx_r >= IDX_W'(4)) rec_nxt.master_data_out = addr8[bit_idx];
        if (job.serve_above) rec_nxt.above_select_drive = sp_code;
        else                 rec_nxt.right_select_drive = sp_code;
      end
      default: final_idx = '0;
    endcase

    last_nxt  = (idx_r == final_idx);
    job_pop   = load && last_nxt;
    idx_nxt   = idx_r;
    valid_nxt = valid_r;
    if (res_pop) valid_nxt = 1'b0;
    if (load) begin
      valid_nxt = 1'b1;
      idx_nxt   = last_nxt ? '0 : idx_r + IDX_W'(1);
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/dcph_checker.sv =====
// Port-level checker for the daisy-chain position handshake and its bind.
// Depends on dcph_pkg and daisy_chain_position_handshake_core.
`timescale 1ns / 1ps
`default_nettype none

module dcph_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_empty,
  input wire logic       out_pop,
  input wire logic [3:0] out_phase,
  input wire logic       out_master_data_out,
  input wire logic       out_master_clock_out,
  input wire logic       out_address_valid
);
  import dcph_pkg::*;

  // Reset leaves no result waiting
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result shown straight after reset");

  // A waiting result stays until taken
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_phase))
    else $error("waiting result dropped or changed");

  // Address valid exactly in the master phases
  a_addr_valid: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> out_address_valid ==
      ((out_phase >= PH_START_MASTER) && (out_phase <= PH_MASTER_SEND)))
    else $error("address valid flag does not match phase");

  // Master pins stay low before the master handshake starts
  a_master_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && (out_phase <= PH_START_MASTER) |->
      !out_master_clock_out && !out_master_data_out)
    else $error("master pins driven before master handshake");

endmodule

bind daisy_chain_position_handshake_core dcph_checker u_dcph_checker (.*);

`default_nettype wire

// ===== sim/tb_daisy_chain_position_handshake_core.sv =====
// Self-checking testbench for daisy_chain_position_handshake_core: pin samples and select
// toggle ticks are pushed in, every popped result is checked against a built-in predictor.
// Depends on dcph_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_daisy_chain_position_handshake_core;
  import dcph_pkg::*;

  // Pin positions within a sampled pin word
  localparam int PIN_CLK   = 0;
  localparam int PIN_DATA  = 1;
  localparam int PIN_LEFT  = 2;
  localparam int PIN_BELOW = 3;
  localparam int PIN_ABOVE = 4;
  localparam int PIN_RIGHT = 5;

  // One result as it leaves the block: record plus end-of-request marker
  typedef struct packed {
    out_rec_t rec;
    logic     last;
  } result_t;

  logic       clk;
  logic       rst_n;
  logic       in_push;
  logic       in_full;
  logic       in_cmd;
  logic       in_slave_clock;
  logic       in_slave_data;
  logic       in_from_left_select;
  logic       in_from_below_select;
  logic       in_to_above_select;
  logic       in_to_right_select;
  logic       out_empty;
  logic       out_pop;
  logic [3:0] out_phase;
  logic [1:0] out_left_select_drive;
  logic [1:0] out_below_select_drive;
  logic       out_master_data_out;
  logic       out_master_clock_out;
  logic [1:0] out_above_select_drive;
  logic [1:0] out_right_select_drive;
  logic [6:0] out_position_address;
  logic       out_address_valid;
  logic       out_last;

  // No idling on either side while set
  bit steady;

  daisy_chain_position_handshake_core dut (.*);

  // Position handshake predictor and store of expected results
  class position_scoreboard;
    phase_t      ph;
    logic [5:0]  prev_pins;
    bit          sel_left;
    bit          via_left;
    bit          via_below;
    bit          to_above;
    logic [3:0]  bits_left;
    logic [7:0]  rx_byte;
    logic [6:0]  addr;
    logic [11:0] drv;
    result_t     pending[$];
    out_rec_t    burst[$];
    int          errors;
    int          requests;
    int          ticks;
    int          checked;

    function new();
      ph        = PH_START_SLAVE;
      prev_pins = '0;
      sel_left  = 1'b1;
      via_left  = 1'b0;
      via_below = 1'b0;
      to_above  = 1'b0;
      bits_left = 4'(VECTOR_BITS);
      rx_byte   = '0;
      addr      = '0;
      drv       = PDL_RESET;
    endfunction

    function logic [1:0] slave_drive(logic dir, logic lvl);
      case ({dir, lvl})
        2'b11:   return SDRV_HIGH;
        2'b10:   return SDRV_LOW;
        2'b01:   return SDRV_PULLUP;
        default: return SDRV_RELEASED;
      endcase
    endfunction

    function logic [1:0] master_drive(logic dir, logic lvl);
      if (!dir) return MDRV_RELEASED;
      return lvl ? MDRV_HIGH : MDRV_LOW;
    endfunction

    // Record the pin drives as they stand now
    function void snap();
      out_rec_t r;
      r.phase              = ph;
      r.left_select_drive  = slave_drive(drv[D_LEFT], drv[D_LEFT + 1]);
      r.below_select_drive = slave_drive(drv[D_BELOW], drv[D_BELOW + 1]);
      r.master_data_out    = drv[D_DATA];
      r.master_clock_out   = drv[D_CLK];
      r.above_select_drive = master_drive(drv[D_ABOVE], drv[D_ABOVE + 1]);
      r.right_select_drive = master_drive(drv[D_RIGHT], drv[D_RIGHT + 1]);
      r.position_address   = addr;
      r.address_valid      = (ph >= PH_START_MASTER) && (ph <= PH_MASTER_SEND);
      burst.push_back(r);
    endfunction

    // Master handshake answer, then the address MSB first, then select driven low again
    function void send_address();
      logic [3:0] sp;
      logic [7:0] word;
      sp   = to_above ? D_ABOVE : D_RIGHT;
      word = {1'b0, addr};
      drv[sp]     = 1'b1;
      drv[sp + 1] = 1'b0;
      snap();
      drv[D_CLK] = 1'b1;
      snap();
      drv[D_CLK] = 1'b0;
      snap();
      drv[sp + 1] = 1'b1;
      snap();
      for (int i = VECTOR_BITS - 1; i >= 0; i--) begin
        drv[D_DATA] = word[i];
        drv[D_CLK]  = 1'b1;
        snap();
        drv[D_CLK] = 1'b0;
        snap();
      end
      drv[sp + 1] = 1'b0;
      snap();
    endfunction

    // Advance the protocol for one accepted request and queue its results
    function void note_request(in_item_t it);
      logic [5:0] cur;
      logic [5:0] chg;
      logic       dat;
      logic       rise;
      logic       fall;
      logic       sel_pin;
      logic [3:0] cp;
      bit         done;
      bit         send;
      result_t    e;
      burst.delete();
      requests++;
      send = 1'b0;
      cp   = sel_left ? D_LEFT : D_BELOW;
      if (it.cmd == CMD_TICK) begin
        ticks++;
        // select toggling only runs while waiting for a master
        if (ph == PH_START_SLAVE) begin
          if (drv[cp + 1]) begin
            drv[cp + 1] = 1'b0;
            snap();
            sel_left = !sel_left;
            cp = sel_left ? D_LEFT : D_BELOW;
            drv[cp + 1] = 1'b1;
            snap();
          end else begin
            drv[cp + 1] = 1'b1;
            snap();
          end
        end
      end else begin
        cur = {it.to_right_select, it.to_above_select, it.from_below_select,
               it.from_left_select, it.slave_data, it.slave_clock};
        chg     = cur ^ prev_pins;
        dat     = cur[PIN_DATA];
        rise    = chg[PIN_CLK] && !prev_pins[PIN_CLK];
        fall    = chg[PIN_CLK] && prev_pins[PIN_CLK];
        sel_pin = sel_left ? cur[PIN_LEFT] : cur[PIN_BELOW];
        case (ph)
          PH_START_SLAVE: begin
            if (rise && dat) begin
              ph = PH_SLAVE_A;
              drv[cp + 1] = 1'b0;
            end
          end
          PH_SLAVE_A: begin
            if (fall) begin
              ph = PH_SLAVE_B;
              drv[cp + 1] = 1'b1;
              snap();
              drv[cp] = 1'b0;
            end else begin
              ph = PH_START_SLAVE;
            end
          end
          PH_SLAVE_B: begin
            if (rise && !dat && !sel_pin) begin
              ph = PH_SERIAL_SLAVE;
              drv[D_LEFT]  = 1'b0;
              drv[D_BELOW] = 1'b0;
            end else begin
              ph = PH_START_SLAVE;
            end
          end
          PH_SERIAL_SLAVE: begin
            // the side that started the transfer masks the other select line
            done = 1'b0;
            if (chg[PIN_BELOW] && !via_left) begin
              if (prev_pins[PIN_BELOW]) done = 1'b1;
              else via_below = 1'b1;
            end else if (chg[PIN_LEFT] && !via_below) begin
              if (prev_pins[PIN_LEFT]) done = 1'b1;
              else via_left = 1'b1;
            end else if (rise && bits_left > 0 && bits_left <= VECTOR_BITS) begin
              bits_left = bits_left - 4'd1;
              rx_byte   = rx_byte | (8'(dat) << bits_left);
            end
            if (done) begin
              bits_left = 4'(VECTOR_BITS);
              addr = 7'(((rx_byte + {7'd0, via_left}) & X_MASK) |
                        ((rx_byte + {4'd0, via_below, 3'd0}) & Y_MASK));
              ph = PH_START_MASTER;
              drv[D_ABOVE] = 1'b0;
              drv[D_RIGHT] = 1'b0;
            end
          end
          PH_START_MASTER: begin
            if (chg[PIN_ABOVE] && !prev_pins[PIN_ABOVE]) begin
              to_above = 1'b1;
              ph = PH_MASTER_A;
            end else if (chg[PIN_RIGHT] && !prev_pins[PIN_RIGHT]) begin
              ph = PH_MASTER_A;
            end
            if (ph == PH_MASTER_A) begin
              drv[D_DATA] = 1'b1;
              drv[D_CLK]  = 1'b1;
            end
          end
          PH_MASTER_A: begin
            if (chg[PIN_RIGHT:PIN_ABOVE] != 0 && prev_pins[PIN_RIGHT:PIN_ABOVE] != 0) begin
              ph = PH_MASTER_B;
              drv[D_DATA] = 1'b0;
              drv[D_CLK]  = 1'b0;
            end
          end
          PH_MASTER_B: begin
            if (chg[PIN_RIGHT:PIN_ABOVE] != 0 && prev_pins[PIN_RIGHT:PIN_ABOVE] == 0) begin
              ph   = PH_MASTER_SEND;
              send = 1'b1;
            end
          end
          default: ;
        endcase
        prev_pins = cur;
        if (send) send_address();
        else snap();
      end
      foreach (burst[i]) begin
        e.rec  = burst[i];
        e.last = (i == burst.size() - 1);
        pending.push_back(e);
      end
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 40) $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    task compare(string field, logic [7:0] got, logic [7:0] want);
      if (got !== want)
        report($sformatf("result %0d: %s is %0h, expected %0h", checked, field, got, want));
    endtask

    // Match a popped result against the oldest expectation
    task check_result(result_t got);
      result_t want;
      if (pending.size() == 0) begin
        report($sformatf("result with nothing expected, phase %0h", got.rec.phase));
      end else begin
        want = pending.pop_front();
        checked++;
        compare("phase", got.rec.phase, want.rec.phase);
        compare("left_select_drive", got.rec.left_select_drive, want.rec.left_select_drive);
        compare("below_select_drive", got.rec.below_select_drive, want.rec.below_select_drive);
        compare("master_data_out", got.rec.master_data_out, want.rec.master_data_out);
        compare("master_clock_out", got.rec.master_clock_out, want.rec.master_clock_out);
        compare("above_select_drive", got.rec.above_select_drive, want.rec.above_select_drive);
        compare("right_select_drive", got.rec.right_select_drive, want.rec.right_select_drive);
        compare("position_address", got.rec.position_address, want.rec.position_address);
        compare("address_valid", got.rec.address_valid, want.rec.address_valid);
        compare("last", got.last, want.last);
      end
    endtask
  endclass

  position_scoreboard sb;

  // Clock, 10 ns period
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Observe both handshakes at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_push && in_full === 1'b0)
        sb.note_request({in_cmd, in_slave_clock, in_slave_data, in_from_left_select,
                         in_from_below_select, in_to_above_select, in_to_right_select});
      if (out_pop && out_empty === 1'b0)
        sb.check_result({out_phase, out_left_select_drive, out_below_select_drive,
                         out_master_data_out, out_master_clock_out, out_above_select_drive,
                         out_right_select_drive, out_position_address, out_address_valid,
                         out_last});
    end
  end

  // Result side stalls at random
  always @(negedge clk)
    out_pop <= rst_n && (steady || $urandom_range(99) >= 19);

  function automatic in_item_t make_item(logic cmd, logic [5:0] pins);
    in_item_t it;
    it.cmd = cmd;
    {it.to_right_select, it.to_above_select, it.from_below_select,
     it.from_left_select, it.slave_data, it.slave_clock} = pins;
    return it;
  endfunction

  // Next request steered by the predicted phase; noise is the percentage of random requests
  function automatic in_item_t shaped_item(int noise);
    logic [5:0] p;
    logic [5:0] c;
    logic       cmd;
    int         own;
    int         other;
    int         roll;
    p    = sb.prev_pins;
    c    = 6'($urandom);
    cmd  = CMD_SAMPLE;
    // random select changes would end a transfer almost at once
    if (sb.ph == PH_SERIAL_SLAVE) noise = noise / 8;
    roll = $urandom_range(99);
    if (roll < noise) begin
      if ($urandom_range(3) == 0) cmd = CMD_TICK;
    end else begin
      roll = $urandom_range(99);
      case (sb.ph)
        PH_START_SLAVE: begin
          if (roll < 25) begin
            cmd = CMD_TICK;
          end else if (p[PIN_CLK]) begin
            c[PIN_CLK] = 1'b0;
          end else begin
            c[PIN_CLK]  = 1'b1;
            c[PIN_DATA] = 1'b1;
          end
        end
        PH_SLAVE_A: c[PIN_CLK] = 1'b0;
        PH_SLAVE_B: begin
          c[PIN_CLK]  = 1'b1;
          c[PIN_DATA] = 1'b0;
          if (sb.sel_left) c[PIN_LEFT] = 1'b0;
          else c[PIN_BELOW] = 1'b0;
        end
        PH_SERIAL_SLAVE: begin
          c = p;
          c[PIN_DATA] = 1'($urandom);
          if (!sb.via_left && !sb.via_below) begin
            if (roll < 10 && (p[PIN_LEFT] || p[PIN_BELOW])) begin
              // a select line falls before any transfer has started
              if (p[PIN_LEFT]) c[PIN_LEFT] = 1'b0;
              else c[PIN_BELOW] = 1'b0;
            end else if (!p[PIN_LEFT] && (p[PIN_BELOW] || roll[0])) begin
              c[PIN_LEFT] = 1'b1;
            end else if (!p[PIN_BELOW]) begin
              c[PIN_BELOW] = 1'b1;
            end else begin
              c[PIN_CLK] = !p[PIN_CLK];
            end
          end else begin
            own   = sb.via_left ? PIN_LEFT : PIN_BELOW;
            other = PIN_LEFT + PIN_BELOW - own;
            if (roll < 10) c[other] = !p[other];
            else if (sb.bits_left == 0 && roll < 40) c[own] = !p[own];
            else c[PIN_CLK] = !p[PIN_CLK];
          end
        end
        PH_START_MASTER: begin
          c = p;
          own = roll[0] ? PIN_ABOVE : PIN_RIGHT;
          c[own] = !p[own];
        end
        PH_MASTER_A, PH_MASTER_B: begin
          // drop the request lines, then raise one again
          c = p;
          if (p[PIN_RIGHT:PIN_ABOVE] != 0) c[PIN_RIGHT:PIN_ABOVE] = 2'b00;
          else c[roll[0] ? PIN_ABOVE : PIN_RIGHT] = 1'b1;
        end
        default: ;
      endcase
    end
    return make_item(cmd, c);
  endfunction

  // Offer one request, idling at random first, and hold it until taken.
  // A non-negative noise steers the request from the predictor, read only after
  // the falling edge so that the previous acceptance is already in it.
  task automatic push_request(input in_item_t it, input int noise);
    @(negedge clk);
    if (noise >= 0) it = shaped_item(noise);
    while (!steady && $urandom_range(99) < 19) begin
      in_push <= 1'b0;
      {in_cmd, in_slave_clock, in_slave_data, in_from_left_select, in_from_below_select,
       in_to_above_select, in_to_right_select} <= 7'($urandom);
      @(negedge clk);
    end
    in_push              <= 1'b1;
    in_cmd               <= it.cmd;
    in_slave_clock       <= it.slave_clock;
    in_slave_data        <= it.slave_data;
    in_from_left_select  <= it.from_left_select;
    in_from_below_select <= it.from_below_select;
    in_to_above_select   <= it.to_above_select;
    in_to_right_select   <= it.to_right_select;
    do @(posedge clk); while (in_full !== 1'b0);
  endtask

  // Stimulus and end of run
  initial begin
    logic [6:0] script [0:16];
    sb      = new();
    rst_n   = 1'b0;
    in_push = 1'b0;
    out_pop = 1'b0;
    steady  = 1'b0;
    {in_cmd, in_slave_clock, in_slave_data, in_from_left_select, in_from_below_select,
     in_to_above_select, in_to_right_select} = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: select toggling, then broken handshakes in slave start, A and B
    script = '{
      {CMD_TICK, 6'h00}, {CMD_TICK, 6'h3F}, {CMD_TICK, 6'h15},
      {CMD_SAMPLE, 6'h00}, {CMD_SAMPLE, 6'b000001}, {CMD_SAMPLE, 6'h00},
      {CMD_SAMPLE, 6'h3F}, {CMD_SAMPLE, 6'h3F}, {CMD_SAMPLE, 6'h00},
      {CMD_SAMPLE, 6'b000011}, {CMD_SAMPLE, 6'b000010}, {CMD_TICK, 6'h2A},
      {CMD_SAMPLE, 6'b000011}, {CMD_SAMPLE, 6'h00}, {CMD_SAMPLE, 6'b000011},
      {CMD_SAMPLE, 6'h00}, {CMD_SAMPLE, 6'b000101}
    };
    foreach (script[i]) push_request(make_item(script[i][6], script[i][5:0]), -1);

    // Random: noisy handshakes first, then mostly clean ones through to the address send
    for (int n = 0; n < 200; n++) begin
      steady = (n >= 40 && n < 80);
      push_request('0, n < 100 ? 40 : 10);
    end
    steady = 1'b0;
    @(negedge clk);
    in_push <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Covered %0d requests including %0d select ticks; %0d results checked.",
             sb.requests, sb.ticks, sb.checked);
    $display("Protocol finished in phase %0d with address y=%0d x=%0d.",
             sb.ph, sb.addr[6:3], sb.addr[2:0]);
    if (sb.errors == 0)
      $display("daisy_chain_position_handshake_core regression: pass");
    else
      $display("daisy_chain_position_handshake_core regression: fail");
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("Timed out waiting for the block.");
    $display("daisy_chain_position_handshake_core regression: fail");
    $finish;
  end

endmodule
